// ===== rtl/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

    // Configuration register index
    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx REG_MODULUS  = 1'b0;
    localparam t_cfg_idx REG_EXPONENT = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input transaction, init working registers
        logic div_step;   // one restoring step of value mod modulus
        logic mul_init;   // clear product accumulators, copy base to multiplier shifter
        logic mul_step;   // one double-and-add step in both product lanes
        logic mul_commit; // last step: write products back, shift exponent
        logic out_load;   // move finished result into output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic mod_zero;   // configured modulus is zero
        logic exp_zero;   // remaining exponent bits are all zero
    } t_dp_sts;

endpackage

// ===== rtl/modexp_req_if.sv =====
// Request channel: valid/ready handshake carrying the value to exponentiate.
interface modexp_req_if #(
    parameter int DATA_WIDTH = 64
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/modexp_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the result and error flag.
interface modexp_rsp_if #(
    parameter int DATA_WIDTH = 64
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result;
    logic                  bad_modulus;

    modport source (output valid, output result, output bad_modulus, input ready);
    modport sink   (input valid, input result, input bad_modulus, output ready);
endinterface

// ===== rtl/modular_exponentiation_64_unit.sv =====
// Modular exponentiation top level: value ^ exponent mod modulus, one result per transaction.
// Steps: a bit-serial reduction of the value by the modulus, then one double-and-add multiply
// pass per exponent bit up to the highest set bit, then the move into the output register.
// A zero modulus skips all arithmetic and returns with the error flag.
// Throughput: one transaction at a time; the bit-serial double-and-add step sets the pace.
// Reset: synchronous, active low; clears the controller, output valid and both configuration registers.
module modular_exponentiation_64_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  modexp_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    modexp_req_if.sink            i_req,
    modexp_rsp_if.source          o_rsp
);
    import modexp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    modexp_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    modexp_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_value       (i_req.value),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_result      (o_rsp.result),
        .o_bad_modulus (o_rsp.bad_modulus)
    );

endmodule

// ===== rtl/modexp_ctrl.sv =====
// Controller state machine: sequences reduction, square-and-multiply and output.
module modexp_ctrl #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  modexp_pkg::t_dp_sts i_sts,
    output modexp_pkg::t_dp_cmd o_cmd
);
    import modexp_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_EXP  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_last;

    assign w_last = (r_cnt == CW'(DATA_WIDTH - 1));

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_sts.mod_zero ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (w_last) begin
                    n_state = S_EXP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EXP: begin
                if (i_sts.exp_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (w_last) begin
                    o_cmd.mul_commit = 1'b1;
                    n_state          = S_EXP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transaction is taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/modexp_dp.sv =====
// Datapath: config registers, bit-serial reduction, two double-and-add lanes, output register.
module modexp_dp #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  modexp_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  modexp_pkg::t_dp_cmd   i_cmd,
    output modexp_pkg::t_dp_sts   o_sts,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_bad_modulus
);
    import modexp_pkg::*;

    localparam int DW = DATA_WIDTH;

    // (x + y) mod m without overflow; exact for x, y < m
    function automatic logic [DW-1:0] add_mod(
        input logic [DW-1:0] x,
        input logic [DW-1:0] y,
        input logic [DW-1:0] m
    );
        logic [DW-1:0] gap;
        gap = m - y;
        if (x >= gap) begin
            return x - gap;
        end else begin
            return x + y;
        end
    endfunction

    logic [DW-1:0] r_mod;
    logic [DW-1:0] r_exp;
    logic [DW-1:0] r_exp_sh;
    logic [DW-1:0] r_val;
    logic [DW-1:0] r_base;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_pa;
    logic [DW-1:0] r_pb;
    logic [DW-1:0] r_ysh;
    logic          r_bad;
    logic [DW-1:0] r_res;
    logic          r_res_bad;

    logic [DW:0]   w_div_t;
    logic [DW-1:0] w_div_sub;
    logic [DW-1:0] w_div_n;
    logic [DW-1:0] w_pa_dbl, w_pb_dbl;
    logic [DW-1:0] n_pa, n_pb;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= '0;
            r_exp <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODULUS) begin
                r_mod <= i_cfg_data;
            end else if (i_cfg_idx == REG_EXPONENT) begin
                r_exp <= i_cfg_data;
            end
        end
    end

    // Restoring reduction step: shift in one value bit, subtract modulus if it fits
    always_comb begin
        w_div_t   = {r_base, r_val[DW-1]};
        w_div_sub = w_div_t[DW-1:0] - r_mod;   // difference is below the modulus
        if (w_div_t >= {1'b0, r_mod}) begin
            w_div_n = w_div_sub;
        end else begin
            w_div_n = w_div_t[DW-1:0];
        end
    end

    // Two multiply lanes sharing multiplier bits of base: acc*base and base*base
    always_comb begin
        w_pa_dbl = add_mod(r_pa, r_pa, r_mod);
        w_pb_dbl = add_mod(r_pb, r_pb, r_mod);
        n_pa     = r_ysh[DW-1] ? add_mod(w_pa_dbl, r_acc, r_mod) : w_pa_dbl;
        n_pb     = r_ysh[DW-1] ? add_mod(w_pb_dbl, r_base, r_mod) : w_pb_dbl;
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val    <= i_value;
            r_base   <= '0;
            r_acc    <= {{(DW-1){1'b0}}, 1'b1};
            r_exp_sh <= r_exp;
            r_bad    <= (r_mod == '0);
        end
        if (i_cmd.div_step) begin
            r_base <= w_div_n;
            r_val  <= {r_val[DW-2:0], 1'b0};
        end
        if (i_cmd.mul_init) begin
            r_pa  <= '0;
            r_pb  <= '0;
            r_ysh <= r_base;
        end
        if (i_cmd.mul_step) begin
            r_pa  <= n_pa;
            r_pb  <= n_pb;
            r_ysh <= {r_ysh[DW-2:0], 1'b0};
        end
        if (i_cmd.mul_commit) begin
            if (r_exp_sh[0]) begin
                r_acc <= n_pa;
            end
            r_base   <= n_pb;
            r_exp_sh <= {1'b0, r_exp_sh[DW-1:1]};
        end
        if (i_cmd.out_load) begin
            r_res     <= r_bad ? '0 : r_acc;
            r_res_bad <= r_bad;
        end
    end

    assign o_sts.mod_zero = (r_mod == '0);
    assign o_sts.exp_zero = (r_exp_sh == '0);
    assign o_result       = r_res;
    assign o_bad_modulus  = r_res_bad;

endmodule

// ===== rtl/modexp_chk.sv =====
// Port-level checker for the modular exponentiation unit, bound to the top level.
module modexp_chk #(
    parameter int DATA_WIDTH = 64
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [DATA_WIDTH-1:0] i_rsp_result,
    input logic                  i_rsp_bad_modulus
);

    // Stalled response transaction holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_result) && $stable(i_rsp_bad_modulus)))
        else $error("response changed while stalled");

    // Bad modulus always comes with a zero result
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_bad_modulus) |-> (i_rsp_result == '0))
        else $error("bad modulus with nonzero result");

    // Block is busy in the cycle after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while previous one in progress");

    // Reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind modular_exponentiation_64_unit modexp_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_result      (o_rsp.result),
    .i_rsp_bad_modulus (o_rsp.bad_modulus)
);
